>>> rtl/core/unesc_pkg.sv
// ----------------------------------------------------------------------------
// unesc_pkg
// Shared types and character constants for the escape sequence unescaper.
// ----------------------------------------------------------------------------
package unesc_pkg;

  // Input transfer: one raw character with its end-of-text flag
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_end;
  } in_t;

  // Output transfer: one decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_end;
  } out_t;

  // Results produced by one consumed character, handed to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    out_t       first;
    out_t       second;
  } push_t;

  // Output queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  // Decoded control bytes
  localparam logic [7:0] BYTE_NL   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_CR   = 8'h0D;

  // Low nibble of a hex letter plus this gives its value (A/a -> 10)
  localparam logic [3:0] HEX_LETTER_ADJ = 4'd9;

endpackage

>>> rtl/core/unesc_step.sv
// ----------------------------------------------------------------------------
// unesc_step
// Input register, parser state and the per-character decode. A held
// character is consumed once the output queue has room for all its results.
// ----------------------------------------------------------------------------
module unesc_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  unesc_pkg::in_t        in_data,
  input  logic [unesc_pkg::QCW-1:0] room,
  output unesc_pkg::push_t      push,
  output logic                  busy
);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  // Registers
  logic                vld;
  unesc_pkg::in_t      data;
  mode_t               mode;
  logic                nibble_waiting;
  logic [3:0]          held_nibble;

  // Next state and decode results
  mode_t               mode_next;
  logic                nibble_waiting_next;
  logic [3:0]          held_nibble_next;
  logic                is_hex;
  logic [3:0]          hex_val;
  logic                plain;
  logic                a_v, p_v, z_v;
  logic [7:0]          a_b, z_b;
  logic [1:0]          cnt;
  unesc_pkg::out_t     first, second;
  logic                consume;
  logic                accept;

  // Hex digit classification
  always_comb begin
    is_hex  = 1'b0;
    hex_val = data.in_char[3:0];
    if (data.in_char >= unesc_pkg::CH_ZERO && data.in_char <= unesc_pkg::CH_NINE) begin
      is_hex = 1'b1;
    end else if ((data.in_char >= unesc_pkg::CH_UA && data.in_char <= unesc_pkg::CH_UF) ||
                 (data.in_char >= unesc_pkg::CH_LA && data.in_char <= unesc_pkg::CH_LF)) begin
      is_hex  = 1'b1;
      hex_val = data.in_char[3:0] + unesc_pkg::HEX_LETTER_ADJ;
    end
  end

  // Character decode: mode part (a), plain part (p), end flush (z)
  always_comb begin
    a_v                 = 1'b0;
    a_b                 = 8'd0;
    p_v                 = 1'b0;
    z_v                 = 1'b0;
    z_b                 = 8'd0;
    plain               = 1'b0;
    mode_next           = mode;
    nibble_waiting_next = nibble_waiting;
    held_nibble_next    = held_nibble;

    case (mode)
      MODE_HEX: begin
        if (is_hex) begin
          if (nibble_waiting) begin
            a_v                 = 1'b1;
            a_b                 = {held_nibble, hex_val};
            nibble_waiting_next = 1'b0;
            held_nibble_next    = 4'd0;
          end else begin
            held_nibble_next    = hex_val;
            nibble_waiting_next = 1'b1;
          end
        end else begin
          // run ends: flush an odd digit, then treat the char as plain text
          if (nibble_waiting) begin
            a_v = 1'b1;
            a_b = {4'd0, held_nibble};
          end
          nibble_waiting_next = 1'b0;
          held_nibble_next    = 4'd0;
          mode_next           = MODE_PLAIN;
          plain               = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (data.in_char == unesc_pkg::CH_N) begin
          a_v = 1'b1;
          a_b = unesc_pkg::BYTE_NL;
        end else if (data.in_char == unesc_pkg::CH_T) begin
          a_v = 1'b1;
          a_b = unesc_pkg::BYTE_TAB;
        end else if (data.in_char == unesc_pkg::CH_R) begin
          a_v = 1'b1;
          a_b = unesc_pkg::BYTE_CR;
        end else if (data.in_char == unesc_pkg::CH_X) begin
          mode_next           = MODE_HEX;
          nibble_waiting_next = 1'b0;
          held_nibble_next    = 4'd0;
        end else begin
          a_v = 1'b1;
          a_b = data.in_char;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // Plain text; a final backslash goes out literally
    if (plain) begin
      if (data.in_char == unesc_pkg::CH_BSLASH && !data.in_end) begin
        mode_next = MODE_ESC;
      end else begin
        p_v = 1'b1;
      end
    end

    // End of text flushes an odd digit and returns to reset state
    if (data.in_end) begin
      z_v                 = (mode_next == MODE_HEX) && nibble_waiting_next;
      z_b                 = {4'd0, held_nibble_next};
      mode_next           = MODE_PLAIN;
      nibble_waiting_next = 1'b0;
      held_nibble_next    = 4'd0;
    end
  end

  // Pack up to two results in order; on end of text tag the last one, or give one empty result
  always_comb begin
    first  = '0;
    second = '0;
    cnt    = {1'b0, a_v} + {1'b0, p_v} + {1'b0, z_v};

    if (a_v) begin
      first = '{out_byte: a_b, byte_present: 1'b1, out_end: 1'b0};
    end else if (p_v) begin
      first = '{out_byte: data.in_char, byte_present: 1'b1, out_end: 1'b0};
    end else if (z_v) begin
      first = '{out_byte: z_b, byte_present: 1'b1, out_end: 1'b0};
    end

    if (a_v && p_v) begin
      second = '{out_byte: data.in_char, byte_present: 1'b1, out_end: 1'b0};
    end else if ((a_v || p_v) && z_v) begin
      second = '{out_byte: z_b, byte_present: 1'b1, out_end: 1'b0};
    end

    if (data.in_end) begin
      if (cnt == 2'd0) begin
        cnt = 2'd1;
      end
      if (cnt == 2'd2) begin
        second.out_end = 1'b1;
      end else begin
        first.out_end = 1'b1;
      end
    end
  end

  // Handshake
  assign consume     = vld && ({1'b0, cnt} <= room);
  assign in_stall    = vld && !consume;
  assign accept      = in_valid && !in_stall;
  assign busy        = vld;
  assign push.cnt    = consume ? cnt : 2'd0;
  assign push.first  = first;
  assign push.second = second;

  // Control and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= 1'b0;
      mode           <= MODE_PLAIN;
      nibble_waiting <= 1'b0;
      held_nibble    <= 4'd0;
    end else begin
      if (accept) begin
        vld <= 1'b1;
      end else if (consume) begin
        vld <= 1'b0;
      end
      if (consume) begin
        mode           <= mode_next;
        nibble_waiting <= nibble_waiting_next;
        held_nibble    <= held_nibble_next;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      data <= in_data;
    end
  end

endmodule

>>> rtl/core/unesc_outq.sv
// ----------------------------------------------------------------------------
// unesc_outq
// Small result queue; takes up to two results a cycle, gives one a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module unesc_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  unesc_pkg::push_t          push,
  output logic [unesc_pkg::QCW-1:0] room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output unesc_pkg::out_t           out_data
);

  unesc_pkg::out_t          q [unesc_pkg::QDEPTH];
  logic [unesc_pkg::QAW-1:0] wr_ptr;
  logic [unesc_pkg::QAW-1:0] rd_ptr;
  logic [unesc_pkg::QCW-1:0] count;
  logic [unesc_pkg::QCW-1:0] count_next;
  logic                      pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  assign room      = unesc_pkg::QCW'(unesc_pkg::QDEPTH) - count;

  always_comb begin
    count_next = count + unesc_pkg::QCW'(push.cnt) - unesc_pkg::QCW'(pop);
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + unesc_pkg::QAW'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      q[wr_ptr + 1'b1] <= push.second;
    end
  end

endmodule

>>> rtl/core/escape_sequence_unescaper.sv
// ----------------------------------------------------------------------------
// escape_sequence_unescaper
// A character passes through the input register, then the output queue, before
// its first result reaches the output. Throughput: one character per cycle;
// a second result from one character is absorbed by the queue, so the input
// stalls only once the queue lacks room for all results of the held character.
// Reset (rst, synchronous): empties the queue and the input register and
// returns the parser to plain text mode.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  unesc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output unesc_pkg::out_t out_data
);

  unesc_pkg::push_t          push;
  logic [unesc_pkg::QCW-1:0] room;
  logic                      busy;

  unesc_step u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push),
    .busy     (busy)
  );

  unesc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An empty result only ever closes the text
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_present |-> out_data.out_end)
    else $error("empty result without end flag");

  // An empty result carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_present |-> out_data.out_byte == 8'd0)
    else $error("empty result with non-zero byte");

  // Input is only held back while a character is pending
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> busy)
    else $error("input stalled with no pending character");

  // A transfer lands in the input register
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> busy)
    else $error("accepted character lost");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape sequence unescaper. A directed run of
// escapes, hex runs and stream ends is followed by random token streams
// (plain text, escapes, hex runs of up to 40 digits, noise). Every accepted
// character is decoded by a local model, and every output transfer is
// checked field by field against the oldest pending decoded result. Both
// sides idle and stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PM_PLAIN = 2'd0,
    PM_ESC   = 2'd1,
    PM_HEX   = 2'd2
  } parse_e;

  // One queued character; hold_first makes the sender wait for the output
  // side to catch up before it goes out
  typedef struct {
    unesc_pkg::in_t data;
    bit             hold_first;
  } char_item_t;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  unesc_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  unesc_pkg::out_t out_data;

  escape_sequence_unescaper u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expected results
  char_item_t      text_q[$];
  unesc_pkg::out_t decoded_q[$];
  bit              hold_next = 1'b0;
  int              n_made    = 0;

  // Decoder model state
  parse_e          esc_state = PM_PLAIN;
  bit              nib_held  = 1'b0;
  logic [3:0]      nib_val   = 4'h0;
  unesc_pkg::out_t step_res[2];
  int              step_n;

  // Bookkeeping
  int              n_err     = 0;
  int              n_chars   = 0;
  int              n_results = 0;
  int              n_streams = 0;
  int              n_two     = 0;
  int              send_gap  = 0;
  int              rx_hold   = 0;
  bit              tx_quiet  = 1'b0;
  bit              rx_quiet  = 1'b0;
  bit              tx_took;
  logic            drained   = 1'b1;
  unesc_pkg::out_t want_res;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= unesc_pkg::CH_ZERO && c <= unesc_pkg::CH_NINE) begin
      v = 4'(c - unesc_pkg::CH_ZERO);
      return 1'b1;
    end
    if (c >= unesc_pkg::CH_LA && c <= unesc_pkg::CH_LF) begin
      v = 4'(c - unesc_pkg::CH_LA + 8'd10);
      return 1'b1;
    end
    if (c >= unesc_pkg::CH_UA && c <= unesc_pkg::CH_UF) begin
      v = 4'(c - unesc_pkg::CH_UA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(unesc_pkg::CH_ZERO + r);
    if (r < 16) return 8'(unesc_pkg::CH_LA + (r - 10));
    return 8'(unesc_pkg::CH_UA + (r - 16));
  endfunction

  function automatic bit rand_end();
    return ($urandom_range(0, 39) == 0);
  endfunction

  task automatic put_char(input logic [7:0] c, input bit last);
    char_item_t it;
    it.data.in_char = c;
    it.data.in_end  = last;
    it.hold_first   = hold_next;
    hold_next       = 1'b0;
    text_q.push_back(it);
    n_made++;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    step_res[step_n] = '{out_byte: b, byte_present: 1'b1, out_end: 1'b0};
    step_n++;
  endtask

  // Decode one accepted character into its expected results
  task automatic decode_char(input unesc_pkg::in_t ch);
    logic [3:0] v;
    bit         is_hex;
    bit         plain;
    is_hex = hex_nibble(ch.in_char, v);
    plain  = 1'b0;
    step_n = 0;
    case (esc_state)
      PM_HEX: begin
        if (is_hex) begin
          if (nib_held) begin
            emit_byte({nib_val, v});
            nib_held = 1'b0;
            nib_val  = 4'h0;
          end else begin
            nib_val  = v;
            nib_held = 1'b1;
          end
        end else begin
          // run broken: flush an odd digit, then treat the char as plain
          if (nib_held) emit_byte({4'h0, nib_val});
          nib_held  = 1'b0;
          nib_val   = 4'h0;
          esc_state = PM_PLAIN;
          plain     = 1'b1;
        end
      end
      PM_ESC: begin
        esc_state = PM_PLAIN;
        case (ch.in_char)
          unesc_pkg::CH_N: emit_byte(unesc_pkg::BYTE_NL);
          unesc_pkg::CH_T: emit_byte(unesc_pkg::BYTE_TAB);
          unesc_pkg::CH_R: emit_byte(unesc_pkg::BYTE_CR);
          unesc_pkg::CH_X: begin
            esc_state = PM_HEX;
            nib_held  = 1'b0;
            nib_val   = 4'h0;
          end
          default: emit_byte(ch.in_char);
        endcase
      end
      default: plain = 1'b1;
    endcase

    // a backslash on the final character goes out literally
    if (plain) begin
      if (ch.in_char == unesc_pkg::CH_BSLASH && !ch.in_end) esc_state = PM_ESC;
      else emit_byte(ch.in_char);
    end

    if (ch.in_end) begin
      if (esc_state == PM_HEX && nib_held) emit_byte({4'h0, nib_val});
      if (step_n == 0) begin
        step_res[0] = '0;
        step_n      = 1;
      end
      step_res[step_n - 1].out_end = 1'b1;
      esc_state = PM_PLAIN;
      nib_held  = 1'b0;
      nib_val   = 4'h0;
      n_streams++;
    end

    if (step_n == 2) n_two++;
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endtask

  // Sender: presents queued characters, holds the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      tx_took = in_valid && !in_stall;
      if (tx_took) begin
        n_chars++;
        send_gap = pick_gap(tx_quiet);
        if ($urandom_range(0, 149) == 0) tx_quiet = !tx_quiet;
      end
      if (!in_valid || tx_took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0 &&
                     (!text_q[0].hold_first || (drained && !tx_took))) begin
          in_valid <= 1'b1;
          in_data  <= text_q[0].data;
          void'(text_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output transfer, then decodes the input transfer
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      drained   <= 1'b1;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: unexpected result byte=%02h present=%0b end=%0b",
                     $realtime, out_data.out_byte, out_data.byte_present,
                     out_data.out_end);
        end else begin
          want_res = decoded_q.pop_front();
          if (out_data.out_byte !== want_res.out_byte ||
              out_data.byte_present !== want_res.byte_present ||
              out_data.out_end !== want_res.out_end) begin
            n_err++;
            if (n_err <= 10)
              $display({"%0t: mismatch exp byte=%02h present=%0b end=%0b, ",
                        "got byte=%02h present=%0b end=%0b"}, $realtime,
                       want_res.out_byte, want_res.byte_present, want_res.out_end,
                       out_data.out_byte, out_data.byte_present, out_data.out_end);
          end
        end
        if ($urandom_range(0, 149) == 0) rx_quiet = !rx_quiet;
      end
      if (in_valid && !in_stall) decode_char(in_data);
      drained <= (decoded_q.size() == 0);

      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_hold = pick_gap(rx_quiet);
      end
    end
  end

  // Stimulus, drain and verdict
  initial begin
    int         kind;
    int         len;
    int         next_hold;
    logic [7:0] c;

    // directed: extremes, each escape, hex runs and the stream-end cases
    put_char(8'h00, 1'b0);
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(8'hFF, 1'b0);
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_N, 1'b0);
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_T, 1'b0);
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_R, 1'b0);
    // even pair, odd digit broken by a plain char (two results)
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_X, 1'b0);
    put_char(unesc_pkg::CH_LA, 1'b0); put_char(unesc_pkg::CH_UF, 1'b0);
    put_char(unesc_pkg::CH_NINE, 1'b0);
    put_char(unesc_pkg::CH_N, 1'b0);
    // hex escape with no digits
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_X, 1'b0);
    put_char(8'h67, 1'b0);
    // odd digit flushed by the stream end
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_X, 1'b0);
    put_char(8'h37, 1'b1);
    // lone final backslash
    put_char(unesc_pkg::CH_BSLASH, 1'b1);
    // hex escape as the final characters: empty end result
    put_char(unesc_pkg::CH_BSLASH, 1'b0); put_char(unesc_pkg::CH_X, 1'b1);

    // random token streams, with a full drain every few hundred characters
    next_hold = n_made;
    while (n_made < 2024) begin
      if (n_made >= next_hold) begin
        hold_next = 1'b1;
        next_hold += 500;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        c = 8'($urandom_range(0, 255));
        if (c == unesc_pkg::CH_BSLASH) c = unesc_pkg::CH_T;
        put_char(c, rand_end());
      end else if (kind < 50) begin
        put_char(unesc_pkg::CH_BSLASH, rand_end());
        case ($urandom_range(0, 2))
          0:       put_char(unesc_pkg::CH_N, rand_end());
          1:       put_char(unesc_pkg::CH_T, rand_end());
          default: put_char(unesc_pkg::CH_R, rand_end());
        endcase
      end else if (kind < 65) begin
        put_char(unesc_pkg::CH_BSLASH, rand_end());
        put_char(8'($urandom_range(0, 255)), rand_end());
      end else if (kind < 90) begin
        put_char(unesc_pkg::CH_BSLASH, rand_end());
        put_char(unesc_pkg::CH_X, rand_end());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
        for (int i = 0; i < len; i++) put_char(rand_hex_char(), rand_end());
      end else begin
        put_char(8'($urandom_range(0, 255)), rand_end());
      end
      if ($urandom_range(0, 9) == 0) text_q[$].data.in_end = 1'b1;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (text_q.size() != 0 || in_valid);
    for (int i = 0; i < 5000 && decoded_q.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $display("%0d decoded results never arrived", decoded_q.size());
      n_err += decoded_q.size();
    end

    $display("sent %0d characters in %0d streams, checked %0d results",
             n_chars, n_streams, n_results);
    $display("%0d characters gave two results, %0d failures", n_two, n_err);
    if (n_err == 0)
      $display("[escape_sequence_unescaper] OK");
    else
      $display("[escape_sequence_unescaper] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #15ms;
    $display("timeout waiting for transfers to complete");
    $display("[escape_sequence_unescaper] ERROR");
    $finish;
  end

endmodule
